// ===== rtl/core/sqd_pkg.sv =====
// ----------------------------------------------------------------------------
// sqd_pkg: shared types and constants for the smallest-three quaternion decoder
// Fixed-point constants for the code scaling and the word handed along the
// square-root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sqd_pkg;

  // Input field layout
  localparam int CodeW = 10;
  localparam int IdxW  = 2;
  localparam int CompW = 16;

  // sqrt2 in Q2.30 and half of the scale divisor 2046 * 2^16
  localparam int unsigned Sqrt2Q30 = 32'd1518500250;
  localparam int unsigned HalfDen  = 32'd67043328;
  // Scaled product is shifted right by 17, then divided by 1023 through
  // multiplication by ceil(2^34 / 1023) and a right shift by 34.
  localparam int ShiftPre   = 17;
  localparam int RecipShift = 34;
  localparam int unsigned Recip1023 = 32'd16793617;

  // Center of the code range (2c - 1023)
  localparam logic [CodeW:0] CodeMid = 11'd1023;

  // 1.0 in Q2.28
  localparam logic [29:0] OneQ28 = 30'd268435456;

  // Root chain: one cell per result bit
  localparam int NumCells = 15;
  localparam int ArgW     = 2 * NumCells;
  localparam int RemW     = 18;
  localparam int RootW    = 16;

  // Word passed from cell to cell
  typedef struct packed {
    logic [ArgW-1:0]          arg;
    logic [RemW-1:0]          rem;
    logic [RootW-1:0]         root;
    logic signed [CompW-1:0]  q0;
    logic signed [CompW-1:0]  q1;
    logic signed [CompW-1:0]  q2;
    logic [IdxW-1:0]          big;
  } root_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/sqd_code_dec.sv =====
// ----------------------------------------------------------------------------
// sqd_code_dec: 10-bit code to signed Q1.14 component
// Two-stage pipeline: scale by sqrt2 with rounding offset, then divide by
// 1023 with a reciprocal multiply and restore the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_code_dec (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [sqd_pkg::CodeW-1:0]         code,
  output logic signed [sqd_pkg::CompW-1:0]       q
);

  logic [sqd_pkg::CodeW:0]    d_pos;
  logic [sqd_pkg::CodeW:0]    d_neg;
  logic [sqd_pkg::CodeW-1:0]  mag;
  logic [40:0]                scaled;
  logic [23:0]                pre_r;
  logic [23:0]                pre_nxt;
  logic                       neg_r;
  logic [48:0]                quot_full;
  logic [13:0]                quot;
  logic signed [sqd_pkg::CompW-1:0] q_r;
  logic signed [sqd_pkg::CompW-1:0] q_nxt;

  // stage 1: |2c - 1023| * sqrt2 + half divisor
  always_comb begin
    d_pos   = {code, 1'b0} - sqd_pkg::CodeMid;
    d_neg   = sqd_pkg::CodeMid - {code, 1'b0};
    mag     = code[sqd_pkg::CodeW-1] ? d_pos[sqd_pkg::CodeW-1:0] : d_neg[sqd_pkg::CodeW-1:0];
    scaled  = 41'(mag) * 41'(sqd_pkg::Sqrt2Q30) + 41'(sqd_pkg::HalfDen);
    pre_nxt = scaled[sqd_pkg::ShiftPre +: 24];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
      neg_r <= ~code[sqd_pkg::CodeW-1];
    end
  end

  // stage 2: divide by 1023, exact for 24-bit dividends
  always_comb begin
    quot_full = 49'(pre_r) * 49'(sqd_pkg::Recip1023);
    quot      = quot_full[sqd_pkg::RecipShift +: 14];
    q_nxt     = neg_r ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/sqd_root_cell.sv =====
// ----------------------------------------------------------------------------
// sqd_root_cell: one digit of the restoring square root
// Takes the next two argument bits into the remainder, tries root bit one,
// and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_root_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire sqd_pkg::root_word_t in_word,
  output logic                     out_vld,
  output sqd_pkg::root_word_t      out_word
);

  logic [sqd_pkg::RemW-1:0]  rem_sh;
  logic [sqd_pkg::RemW-1:0]  trial;
  logic                      take;
  logic                      vld_r;
  sqd_pkg::root_word_t       word_r;
  sqd_pkg::root_word_t       word_nxt;

  // trial subtract of (4*root + 1)
  always_comb begin
    rem_sh   = {in_word.rem[sqd_pkg::RemW-3:0], in_word.arg[sqd_pkg::ArgW-1 -: 2]};
    trial    = {in_word.root, 2'b01};
    take     = (rem_sh >= trial);
    word_nxt = in_word;
    word_nxt.arg  = {in_word.arg[sqd_pkg::ArgW-3:0], 2'b00};
    word_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    word_nxt.root = {in_word.root[sqd_pkg::RootW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

`default_nettype wire

// ===== rtl/core/smallest_three_quat_decode.sv =====
// ----------------------------------------------------------------------------
// smallest_three_quat_decode: 32-bit smallest-three quaternion decoder
// Unpacks the largest-component index and three 10-bit codes, scales the
// codes to Q1.14 and rebuilds the largest component by a square-root chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_packed_high / in_packed_low with in_valid and
//   in_ready; decoded components leave on out_comp_x..w with out_valid and
//   out_ready. One word is accepted per cycle while the output moves.
//   The pipeline runs through code scaling (stages A and B), the squares
//   (stage C), the root argument (stage D), fifteen root cells (one result
//   bit per cell) and a final stage for rounding and placing components.
//   Throughput is one word per cycle unless stalled; stages advance together.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and in_ready drops; it rises again the cycle the waiting word is taken.
//   Reset clears all stage valid flags, so no word is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_three_quat_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_packed_high,
  input  wire logic [15:0]        in_packed_low,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_comp_x,
  output logic signed [15:0]      out_comp_y,
  output logic signed [15:0]      out_comp_z,
  output logic signed [15:0]      out_comp_w
);

  logic en;
  logic in_acc;

  logic [sqd_pkg::CodeW-1:0] code0;
  logic [sqd_pkg::CodeW-1:0] code1;
  logic [sqd_pkg::CodeW-1:0] code2;
  logic signed [sqd_pkg::CompW-1:0] dq0;
  logic signed [sqd_pkg::CompW-1:0] dq1;
  logic signed [sqd_pkg::CompW-1:0] dq2;

  logic va_r, vb_r, vc_r, vd_r;
  logic [sqd_pkg::IdxW-1:0] big_a_r, big_b_r, big_c_r;
  logic signed [sqd_pkg::CompW-1:0] q0_c_r, q1_c_r, q2_c_r;
  logic [27:0] sq0_c_r, sq1_c_r, sq2_c_r;
  logic [27:0] sq0_nxt, sq1_nxt, sq2_nxt;
  logic signed [31:0] p0, p1, p2;

  logic [29:0] sum_d;
  sqd_pkg::root_word_t word_d_r;
  sqd_pkg::root_word_t word_d_nxt;

  logic                cell_vld [0:sqd_pkg::NumCells];
  sqd_pkg::root_word_t cell_w   [0:sqd_pkg::NumCells];

  sqd_pkg::root_word_t fin;
  logic [sqd_pkg::RootW-1:0] root_rnd;
  logic signed [15:0] root_s;
  logic signed [15:0] cx_nxt, cy_nxt, cz_nxt, cw_nxt;
  logic signed [15:0] cx_r, cy_r, cz_r, cw_r;
  logic               out_valid_r;
  logic [sqd_pkg::IdxW-1:0] big_o_r;
  logic signed [15:0] root_o;

  // pipeline advances whenever the output register is free or being drained
  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;
  assign in_acc   = in_valid & in_ready;

  // field split
  assign code0 = in_packed_high[13:4];
  assign code1 = {in_packed_high[3:0], in_packed_low[15:10]};
  assign code2 = in_packed_low[9:0];

  // code scaling lanes (stages A and B)
  sqd_code_dec u_dec0 (.clk(clk), .en(en), .code(code0), .q(dq0));
  sqd_code_dec u_dec1 (.clk(clk), .en(en), .code(code1), .q(dq1));
  sqd_code_dec u_dec2 (.clk(clk), .en(en), .code(code2), .q(dq2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_acc;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // index rides alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      big_a_r <= in_packed_high[15:14];
      big_b_r <= big_a_r;
    end
  end

  // stage C: squares
  always_comb begin
    p0      = 32'(dq0) * 32'(dq0);
    p1      = 32'(dq1) * 32'(dq1);
    p2      = 32'(dq2) * 32'(dq2);
    sq0_nxt = p0[27:0];
    sq1_nxt = p1[27:0];
    sq2_nxt = p2[27:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_c_r  <= dq0;
      q1_c_r  <= dq1;
      q2_c_r  <= dq2;
      sq0_c_r <= sq0_nxt;
      sq1_c_r <= sq1_nxt;
      sq2_c_r <= sq2_nxt;
      big_c_r <= big_b_r;
    end
  end

  // stage D: root argument, saturated at zero
  always_comb begin
    sum_d           = 30'(sq0_c_r) + 30'(sq1_c_r) + 30'(sq2_c_r);
    word_d_nxt.arg  = (sum_d >= sqd_pkg::OneQ28) ? '0 : (sqd_pkg::OneQ28 - sum_d);
    word_d_nxt.rem  = '0;
    word_d_nxt.root = '0;
    word_d_nxt.q0   = q0_c_r;
    word_d_nxt.q1   = q1_c_r;
    word_d_nxt.q2   = q2_c_r;
    word_d_nxt.big  = big_c_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_d_r <= word_d_nxt;
    end
  end

  // square-root cell chain
  assign cell_vld[0] = vd_r;
  assign cell_w[0]   = word_d_r;

  for (genvar i = 0; i < sqd_pkg::NumCells; i++) begin : g_cell
    sqd_root_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (cell_vld[i]),
      .in_word (cell_w[i]),
      .out_vld (cell_vld[i+1]),
      .out_word(cell_w[i+1])
    );
  end

  // final stage: round root to nearest and place components
  always_comb begin
    fin      = cell_w[sqd_pkg::NumCells];
    root_rnd = (fin.rem > {2'b00, fin.root}) ? (fin.root + 16'd1) : fin.root;
    root_s   = $signed(root_rnd);
    cx_nxt   = root_s;
    cy_nxt   = root_s;
    cz_nxt   = root_s;
    cw_nxt   = root_s;
    unique case (fin.big)
      2'd0: begin
        cy_nxt = fin.q0; cz_nxt = fin.q1; cw_nxt = fin.q2;
      end
      2'd1: begin
        cz_nxt = fin.q0; cw_nxt = fin.q1; cx_nxt = fin.q2;
      end
      2'd2: begin
        cw_nxt = fin.q0; cx_nxt = fin.q1; cy_nxt = fin.q2;
      end
      default: begin
        cx_nxt = fin.q0; cy_nxt = fin.q1; cz_nxt = fin.q2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cell_vld[sqd_pkg::NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      cz_r    <= cz_nxt;
      cw_r    <= cw_nxt;
      big_o_r <= fin.big;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_comp_x = cx_r;
  assign out_comp_y = cy_r;
  assign out_comp_z = cz_r;
  assign out_comp_w = cw_r;

  // rebuilt component as seen on the output
  always_comb begin
    unique case (big_o_r)
      2'd0:    root_o = cx_r;
      2'd1:    root_o = cy_r;
      2'd2:    root_o = cz_r;
      default: root_o = cw_r;
    endcase
  end

  // rebuilt component stays within 0 .. 1.0
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (root_o >= 16'sd0 && root_o <= 16'sd16384))
    else $error("rebuilt component out of range");

  // root argument never exceeds 1.0
  a_arg_range: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r |-> (word_d_r.arg <= sqd_pkg::OneQ28))
    else $error("root argument above one");

  // accepted word enters stage A
  a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> va_r)
    else $error("accepted word lost at stage A");

  // a stall freezes the valid flags of stage A, stage D and the last root cell
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(va_r) && $stable(vd_r) && $stable(cell_vld[sqd_pkg::NumCells])))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
